[sv/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions for the complex arithmetic unit
// Number format, function and status codes, the divider cell payload and
// the saturation helper used by the output stage.
// ----------------------------------------------------------------------------
package cau_pkg;

    // Number format
    localparam int WIDTH     = 32;
    localparam int FRAC_BITS = 16;

    // Derived widths: products/magnitudes, exact sums, shifted dividend, compare
    localparam int PW = 2 * WIDTH;
    localparam int SW = PW + 1;
    localparam int CW = PW + FRAC_BITS + WIDTH;

    // Fixed-point 1.0 in sum width
    localparam logic signed [SW-1:0] FIX_ONE = SW'(1) << FRAC_BITS;

    // Function codes
    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_MUL = 4'd2;
    localparam logic [3:0] FN_DIV = 4'd3;
    localparam logic [3:0] FN_INC = 4'd4;
    localparam logic [3:0] FN_DEC = 4'd5;
    localparam logic [3:0] FN_GT  = 4'd6;
    localparam logic [3:0] FN_LT  = 4'd7;
    localparam logic [3:0] FN_EQ  = 4'd8;
    localparam logic [3:0] FN_NE  = 4'd9;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Payload handed from cell to cell. For non-divide operations rem holds
    // the final magnitude and passes through untouched.
    typedef struct packed {
        logic             is_div;
        logic             dz;
        logic             cmp;
        logic             neg_r;
        logic             neg_i;
        logic             ovf_r;
        logic             ovf_i;
        logic [PW-1:0]    den;
        logic [PW-1:0]    rem_r;
        logic [PW-1:0]    rem_i;
        logic [WIDTH-1:0] dq_r;
        logic [WIDTH-1:0] dq_i;
    } cau_cell_t;

    typedef struct packed {
        logic [WIDTH-1:0] val;
        logic             sat;
    } cau_sat_t;

    // Sign and magnitude to a saturated WIDTH-bit value
    function automatic cau_sat_t sat_part(input logic neg, input logic [PW-1:0] mag);
        logic [PW-1:0] limit;
        cau_sat_t      r;
        limit = PW'(1) << (WIDTH - 1);
        r.sat = 1'b0;
        if (neg)
        begin
            if (mag > limit)
            begin
                r.val = limit[WIDTH-1:0];
                r.sat = 1'b1;
            end
            else
            begin
                r.val = -mag[WIDTH-1:0];
            end
        end
        else
        begin
            if (mag > limit - PW'(1))
            begin
                r.val = limit[WIDTH-1:0] - WIDTH'(1);
                r.sat = 1'b1;
            end
            else
            begin
                r.val = mag[WIDTH-1:0];
            end
        end
        return r;
    endfunction

endpackage

[sv/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front: operand capture, products, sums and divider setup
// Four pipeline stages with per-stage valid; bubbles collapse on a stall.
// ----------------------------------------------------------------------------
module cau_front
    import cau_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          func,
    input  logic signed [31:0]  a_real,
    input  logic signed [31:0]  a_imag,
    input  logic signed [31:0]  b_real,
    input  logic signed [31:0]  b_imag,
    output logic                down_valid,
    input  logic                down_ready,
    output cau_cell_t           down_data
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    logic [3:0]              func1_reg, func2_reg, func3_reg;
    logic signed [WIDTH-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [WIDTH-1:0] ar2_reg, ai2_reg, br2_reg, bi2_reg;
    logic signed [PW-1:0]    p_rr2_reg, p_ii2_reg, p_ri2_reg, p_ir2_reg;
    logic signed [PW-1:0]    sq_ar2_reg, sq_ai2_reg, sq_br2_reg, sq_bi2_reg;
    logic signed [SW-1:0]    sr3_reg, si3_reg, sr3_next, si3_next;
    logic [PW-1:0]           den3_reg, ma3_reg, mb3_reg;
    logic                    eq3_reg;
    cau_cell_t               cell4_reg, cell4_next;

    logic signed [SW-1:0]    abs_r, abs_i;
    logic [PW-1:0]           mag_r, mag_i;
    logic [CW-1:0]           wide_r, wide_i, den_wide;

    // Ready ripples back from the divider chain
    assign r4       = !v4_reg || down_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    assign down_valid = v4_reg;
    assign down_data  = cell4_reg;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    // Stage 3 sums
    always_comb
    begin
        sr3_next = '0;
        si3_next = '0;
        unique case (func2_reg)
            FN_ADD:
            begin
                sr3_next = SW'(ar2_reg) + SW'(br2_reg);
                si3_next = SW'(ai2_reg) + SW'(bi2_reg);
            end
            FN_SUB:
            begin
                sr3_next = SW'(ar2_reg) - SW'(br2_reg);
                si3_next = SW'(ai2_reg) - SW'(bi2_reg);
            end
            FN_INC:
            begin
                sr3_next = SW'(ar2_reg) + FIX_ONE;
                si3_next = SW'(ai2_reg) + FIX_ONE;
            end
            FN_DEC:
            begin
                sr3_next = SW'(ar2_reg) - FIX_ONE;
                si3_next = SW'(ai2_reg) - FIX_ONE;
            end
            FN_MUL:
            begin
                sr3_next = SW'(p_rr2_reg) - SW'(p_ii2_reg);
                si3_next = SW'(p_ri2_reg) + SW'(p_ir2_reg);
            end
            FN_DIV:
            begin
                sr3_next = SW'(p_rr2_reg) + SW'(p_ii2_reg);
                si3_next = SW'(p_ir2_reg) - SW'(p_ri2_reg);
            end
            default:
            begin
                sr3_next = '0;
                si3_next = '0;
            end
        endcase
    end

    // Stage 4: sign/magnitude split and divider setup
    always_comb
    begin
        abs_r    = sr3_reg[SW-1] ? -sr3_reg : sr3_reg;
        abs_i    = si3_reg[SW-1] ? -si3_reg : si3_reg;
        mag_r    = abs_r[PW-1:0];
        mag_i    = abs_i[PW-1:0];
        wide_r   = CW'(mag_r) << FRAC_BITS;
        wide_i   = CW'(mag_i) << FRAC_BITS;
        den_wide = CW'(den3_reg) << WIDTH;
        cell4_next = '0;
        unique case (func3_reg)
            FN_ADD, FN_SUB, FN_INC, FN_DEC:
            begin
                cell4_next.neg_r = sr3_reg[SW-1];
                cell4_next.neg_i = si3_reg[SW-1];
                cell4_next.rem_r = mag_r;
                cell4_next.rem_i = mag_i;
            end
            FN_MUL:
            begin
                cell4_next.neg_r = sr3_reg[SW-1];
                cell4_next.neg_i = si3_reg[SW-1];
                cell4_next.rem_r = mag_r >> FRAC_BITS;
                cell4_next.rem_i = mag_i >> FRAC_BITS;
            end
            FN_DIV:
            begin
                if (den3_reg == '0)
                begin
                    cell4_next.dz = 1'b1;
                end
                else
                begin
                    cell4_next.is_div = 1'b1;
                    cell4_next.den    = den3_reg;
                    cell4_next.neg_r  = sr3_reg[SW-1];
                    cell4_next.neg_i  = si3_reg[SW-1];
                    cell4_next.rem_r  = PW'(wide_r >> WIDTH);
                    cell4_next.rem_i  = PW'(wide_i >> WIDTH);
                    cell4_next.dq_r   = wide_r[WIDTH-1:0];
                    cell4_next.dq_i   = wide_i[WIDTH-1:0];
                    cell4_next.ovf_r  = wide_r >= den_wide;
                    cell4_next.ovf_i  = wide_i >= den_wide;
                end
            end
            FN_GT:   cell4_next.cmp = ma3_reg > mb3_reg;
            FN_LT:   cell4_next.cmp = ma3_reg < mb3_reg;
            FN_EQ:   cell4_next.cmp = eq3_reg;
            FN_NE:   cell4_next.cmp = !eq3_reg;
            default: cell4_next.cmp = 1'b0;
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            func1_reg <= func;
            ar1_reg   <= a_real[WIDTH-1:0];
            ai1_reg   <= a_imag[WIDTH-1:0];
            br1_reg   <= b_real[WIDTH-1:0];
            bi1_reg   <= b_imag[WIDTH-1:0];
        end
        if (r2 && v1_reg)
        begin
            func2_reg  <= func1_reg;
            ar2_reg    <= ar1_reg;
            ai2_reg    <= ai1_reg;
            br2_reg    <= br1_reg;
            bi2_reg    <= bi1_reg;
            p_rr2_reg  <= ar1_reg * br1_reg;
            p_ii2_reg  <= ai1_reg * bi1_reg;
            p_ri2_reg  <= ar1_reg * bi1_reg;
            p_ir2_reg  <= ai1_reg * br1_reg;
            sq_ar2_reg <= ar1_reg * ar1_reg;
            sq_ai2_reg <= ai1_reg * ai1_reg;
            sq_br2_reg <= br1_reg * br1_reg;
            sq_bi2_reg <= bi1_reg * bi1_reg;
        end
        if (r3 && v2_reg)
        begin
            func3_reg <= func2_reg;
            sr3_reg   <= sr3_next;
            si3_reg   <= si3_next;
            den3_reg  <= $unsigned(sq_br2_reg) + $unsigned(sq_bi2_reg);
            ma3_reg   <= $unsigned(sq_ar2_reg) + $unsigned(sq_ai2_reg);
            mb3_reg   <= $unsigned(sq_br2_reg) + $unsigned(sq_bi2_reg);
            eq3_reg   <= (ar2_reg == br2_reg) && (ai2_reg == bi2_reg);
        end
        if (r4 && v3_reg)
        begin
            cell4_reg <= cell4_next;
        end
    end

endmodule

[sv/cau_div_cell.sv]
// ----------------------------------------------------------------------------
// cau_div_cell: one restoring-division cell
// Produces one quotient bit for both parts per transaction and hands the
// payload to the next cell; non-divide payloads pass through unchanged.
// ----------------------------------------------------------------------------
module cau_div_cell
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  cau_cell_t up_data,
    output logic      down_valid,
    input  logic      down_ready,
    output cau_cell_t down_data
);

    logic      valid_reg;
    cau_cell_t data_reg, data_next;

    // Shift in the next dividend bit, compare-subtract, shift out the quotient bit
    function automatic logic [PW+WIDTH-1:0] step(input logic [PW-1:0] rem,
                                                  input logic [WIDTH-1:0] dq,
                                                  input logic [PW-1:0] den);
        logic [PW:0] t;
        logic [PW:0] d;
        logic        ge;
        t  = {rem, dq[WIDTH-1]};
        d  = {1'b0, den};
        ge = t >= d;
        if (ge) t = t - d;
        return {t[PW-1:0], dq[WIDTH-2:0], ge};
    endfunction

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // Divide step
    always_comb
    begin
        data_next = up_data;
        if (up_data.is_div)
        begin
            {data_next.rem_r, data_next.dq_r} = step(up_data.rem_r, up_data.dq_r, up_data.den);
            {data_next.rem_i, data_next.dq_i} = step(up_data.rem_i, up_data.dq_i, up_data.den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[sv/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: fixed-point complex ALU
// Operands are Q16.16. Pipeline: four front stages, one division cell per
// quotient bit, one output register. Throughput is one transaction per
// cycle for every function while out_stall is low; the divider cell chain sets
// the depth. Reset clears all valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         func,
    input  logic signed [31:0] a_real,
    input  logic signed [31:0] a_imag,
    input  logic signed [31:0] b_real,
    input  logic signed [31:0] b_imag,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_real,
    output logic signed [31:0] res_imag,
    output logic               compare_true,
    output logic [1:0]         status
);

    logic      link_valid [0:WIDTH];
    logic      link_ready [0:WIDTH];
    cau_cell_t link_data  [0:WIDTH];
    logic      in_ready;

    logic               out_valid_reg, out_ready;
    logic signed [31:0] res_real_reg, res_imag_reg;
    logic               compare_true_reg;
    logic [1:0]         status_reg, status_next;
    logic [PW-1:0]      mag_r, mag_i;
    cau_sat_t           sat_r, sat_i;
    cau_cell_t          last;

    // Front stages
    cau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .a_real     (a_real),
        .a_imag     (a_imag),
        .b_real     (b_real),
        .b_imag     (b_imag),
        .down_valid (link_valid[0]),
        .down_ready (link_ready[0]),
        .down_data  (link_data[0])
    );

    assign in_stall = !in_ready;

    // Divider cell chain, one quotient bit per cell
    for (genvar k = 0; k < WIDTH; k++)
    begin : g_cell
        cau_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[k]),
            .up_ready   (link_ready[k]),
            .up_data    (link_data[k]),
            .down_valid (link_valid[k+1]),
            .down_ready (link_ready[k+1]),
            .down_data  (link_data[k+1])
        );
    end

    assign out_ready          = !out_valid_reg || !out_stall;
    assign link_ready[WIDTH]  = out_ready;
    assign last               = link_data[WIDTH];

    // Final saturation and status
    always_comb
    begin
        mag_r = last.is_div ? (last.ovf_r ? '1 : PW'(last.dq_r)) : last.rem_r;
        mag_i = last.is_div ? (last.ovf_i ? '1 : PW'(last.dq_i)) : last.rem_i;
        sat_r = sat_part(last.neg_r, mag_r);
        sat_i = sat_part(last.neg_i, mag_i);
        if (last.dz)
            status_next = ST_DIV0;
        else if (sat_r.sat || sat_i.sat)
            status_next = ST_SAT;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= link_valid[WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && link_valid[WIDTH])
        begin
            res_real_reg     <= 32'($signed(sat_r.val));
            res_imag_reg     <= 32'($signed(sat_i.val));
            compare_true_reg <= last.cmp;
            status_reg       <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign res_real     = res_real_reg;
    assign res_imag     = res_imag_reg;
    assign compare_true = compare_true_reg;
    assign status       = status_reg;

    // Checks
    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DIV0 |-> res_real == 0 && res_imag == 0)
        else $error("divide by zero result not zero");

    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && compare_true |-> status == ST_OK && res_real == 0 && res_imag == 0)
        else $error("comparison result carries arithmetic data");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule
